// ===== rtl/core/fspd_pkg.sv =====
// ----------------------------------------------------------------------------
// fspd_pkg
// Shared widths, operation codes, result kinds, phase codes and register
// indexes of the foot support phase detector.
// ----------------------------------------------------------------------------
package fspd_pkg;

  localparam int CELL_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int THRESH_W   = 18;
  localparam int PRESS_W    = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  typedef logic [1:0] op_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] phase_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_LEFT  = 2'd0;
  localparam op_t OP_RIGHT = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  localparam kind_t KIND_PHASE = 2'd0;
  localparam kind_t KIND_LEFT  = 2'd1;
  localparam kind_t KIND_RIGHT = 2'd2;

  localparam phase_t PHASE_LEFT   = 2'd0;
  localparam phase_t PHASE_RIGHT  = 2'd1;
  localparam phase_t PHASE_DOUBLE = 2'd2;

  localparam cfg_idx_t REG_FILTER_WEIGHT   = 2'd0;
  localparam cfg_idx_t REG_THRESHOLD_LEFT  = 2'd1;
  localparam cfg_idx_t REG_THRESHOLD_RIGHT = 2'd2;
  localparam cfg_idx_t REG_DEBUG_ENABLE    = 2'd3;

endpackage

// ===== rtl/core/fspd_if.sv =====
// ----------------------------------------------------------------------------
// fspd_if
// Valid/ready channels of the foot support phase detector: the sample and
// tick input channel and the result channel.
// ----------------------------------------------------------------------------
interface fspd_in_if import fspd_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [CELL_W-1:0] cell_left_back;
  logic [CELL_W-1:0] cell_left_front;
  logic [CELL_W-1:0] cell_right_front;
  logic [CELL_W-1:0] cell_right_back;

  modport source (
    output valid, op, cell_left_back, cell_left_front, cell_right_front,
           cell_right_back,
    input  ready
  );
  modport sink (
    input  valid, op, cell_left_back, cell_left_front, cell_right_front,
           cell_right_back,
    output ready
  );
endinterface

interface fspd_out_if import fspd_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  phase_t             phase;
  logic [PRESS_W-1:0] filtered_pressure;

  modport source (
    output valid, kind, phase, filtered_pressure,
    input  ready
  );
  modport sink (
    input  valid, kind, phase, filtered_pressure,
    output ready
  );
endinterface

// ===== rtl/core/fspd_cell_sum.sv =====
// ----------------------------------------------------------------------------
// fspd_cell_sum
// Adds the low min(CELL_BITS, CELL_W) bits of four pressure cells of a sample.
// ----------------------------------------------------------------------------
module fspd_cell_sum import fspd_pkg::*; #(
  parameter int CELL_BITS = 16
) (
  input  logic [CELL_W-1:0]      cell_a,
  input  logic [CELL_W-1:0]      cell_b,
  input  logic [CELL_W-1:0]      cell_c,
  input  logic [CELL_W-1:0]      cell_d,
  output logic [CELL_BITS+1:0]   sum
);

  localparam int SUM_BITS = CELL_BITS + 2;
  localparam int USE_BITS = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;

  assign sum = SUM_BITS'(cell_a[USE_BITS-1:0]) + SUM_BITS'(cell_b[USE_BITS-1:0])
             + SUM_BITS'(cell_c[USE_BITS-1:0]) + SUM_BITS'(cell_d[USE_BITS-1:0]);

endmodule

// ===== rtl/core/fspd_lowpass.sv =====
// ----------------------------------------------------------------------------
// fspd_lowpass
// First-order low-pass update of one foot, new = sum + ((w*(old-sum)) >>> 16),
// and the strict threshold compare for standing.
// ----------------------------------------------------------------------------
module fspd_lowpass import fspd_pkg::*; #(
  parameter int CELL_BITS = 16
) (
  input  logic [CELL_BITS+1:0] sum,
  input  logic [CELL_BITS+1:0] old,
  input  logic [WEIGHT_W-1:0]  weight,
  input  logic [THRESH_W-1:0]  threshold,
  output logic [CELL_BITS+1:0] filt_new,
  output logic                 standing
);

  localparam int SUM_BITS = CELL_BITS + 2;
  localparam int PROD_W   = SUM_BITS + WEIGHT_W + 2;
  localparam int CMP_W    = (SUM_BITS > THRESH_W) ? SUM_BITS : THRESH_W;

  logic signed [SUM_BITS:0]   diff;
  logic signed [WEIGHT_W:0]   w_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   acc;

  assign diff = $signed({1'b0, old}) - $signed({1'b0, sum});
  assign w_s  = $signed({1'b0, weight});
  assign prod = PROD_W'(diff) * PROD_W'(w_s);
  assign acc  = $signed(PROD_W'({1'b0, sum})) + (prod >>> WEIGHT_W);

  assign filt_new = acc[SUM_BITS-1:0];
  assign standing = CMP_W'(filt_new) > CMP_W'(threshold);

endmodule

// ===== rtl/core/foot_support_phase_detector_top.sv =====
// ----------------------------------------------------------------------------
// foot_support_phase_detector_top
// Foot support phase detector: low-pass filtered foot pressure and stance
// phase change reporting.
//
// in_ch carries left samples, right samples and ticks (valid/ready). A
// sample sums its four cells into an input register; when it advances from
// there, it updates that foot's filtered value and standing flag and, with
// debug enabled, loads a filtered value result. A tick derives the stance
// phase and loads a phase result only when the phase changes.
// out_ch presents results from an output register, loaded when an item
// advances from the input register; one item is taken every cycle while no
// result is blocked, since the filter multiply-add and threshold compare
// are combinational between the input and output registers.
// When the receiver stalls, the result holds and the input register keeps
// taking items that give no result; an item that gives one waits there and
// in_ch.ready drops.
// cfg_we/cfg_index/cfg_wdata write the weight, thresholds and debug enable.
// Reset clears filter state, standing flags and registers and sets the last
// phase to double stance; no item is held.
// ----------------------------------------------------------------------------
module foot_support_phase_detector_top import fspd_pkg::*; #(
  parameter int CELL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fspd_in_if.sink               in_ch,
  fspd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_BITS = CELL_BITS + 2;

  logic [WEIGHT_W-1:0] weight_r;
  logic [THRESH_W-1:0] thr_left_r;
  logic [THRESH_W-1:0] thr_right_r;
  logic                dbg_r;

  logic [SUM_BITS-1:0] filt_left_r;
  logic [SUM_BITS-1:0] filt_right_r;
  logic                stand_left_r;
  logic                stand_right_r;
  phase_t              last_phase_r;

  logic                s1_valid_r;
  op_t                 s1_op_r;
  logic [SUM_BITS-1:0] s1_sum_r;
  logic [SUM_BITS-1:0] in_sum;

  logic                out_valid_r;
  kind_t               out_kind_r;
  phase_t              out_phase_r;
  logic [PRESS_W-1:0]  out_press_r;
  kind_t               out_kind_nxt;
  phase_t              out_phase_nxt;
  logic [PRESS_W-1:0]  out_press_nxt;

  logic                is_left;
  logic                is_right;
  logic                is_tick;
  logic [SUM_BITS-1:0] old_sel;
  logic [THRESH_W-1:0] thr_sel;
  logic [SUM_BITS-1:0] filt_new;
  logic                standing;
  phase_t              phase_now;
  logic                s1_emit;
  logic                s1_adv;
  logic                in_xfer;

  fspd_cell_sum #(.CELL_BITS(CELL_BITS)) u_sum (
    .cell_a (in_ch.cell_left_back),
    .cell_b (in_ch.cell_left_front),
    .cell_c (in_ch.cell_right_front),
    .cell_d (in_ch.cell_right_back),
    .sum    (in_sum)
  );

  assign is_left  = (s1_op_r == OP_LEFT);
  assign is_right = (s1_op_r == OP_RIGHT);
  assign is_tick  = (s1_op_r == OP_TICK);
  assign old_sel  = is_right ? filt_right_r : filt_left_r;
  assign thr_sel  = is_right ? thr_right_r : thr_left_r;

  fspd_lowpass #(.CELL_BITS(CELL_BITS)) u_lowpass (
    .sum       (s1_sum_r),
    .old       (old_sel),
    .weight    (weight_r),
    .threshold (thr_sel),
    .filt_new  (filt_new),
    .standing  (standing)
  );

  always_comb begin
    if (stand_left_r && !stand_right_r) begin
      phase_now = PHASE_LEFT;
    end else if (!stand_left_r && stand_right_r) begin
      phase_now = PHASE_RIGHT;
    end else begin
      phase_now = PHASE_DOUBLE;
    end
  end

  assign s1_emit     = ((is_left || is_right) && dbg_r) ||
                       (is_tick && (phase_now != last_phase_r));
  assign s1_adv      = s1_valid_r && (!s1_emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (is_tick) begin
      out_kind_nxt  = KIND_PHASE;
      out_phase_nxt = phase_now;
      out_press_nxt = '0;
    end else begin
      out_kind_nxt  = is_right ? KIND_RIGHT : KIND_LEFT;
      out_phase_nxt = PHASE_LEFT;
      out_press_nxt = PRESS_W'(filt_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= '0;
      thr_left_r  <= '0;
      thr_right_r <= '0;
      dbg_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_WEIGHT:   weight_r    <= cfg_wdata[WEIGHT_W-1:0];
        REG_THRESHOLD_LEFT:  thr_left_r  <= cfg_wdata[THRESH_W-1:0];
        REG_THRESHOLD_RIGHT: thr_right_r <= cfg_wdata[THRESH_W-1:0];
        REG_DEBUG_ENABLE:    dbg_r       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= in_ch.op;
      s1_sum_r <= in_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_left_r   <= '0;
      filt_right_r  <= '0;
      stand_left_r  <= 1'b0;
      stand_right_r <= 1'b0;
      last_phase_r  <= PHASE_DOUBLE;
    end else if (s1_adv) begin
      if (is_left) begin
        filt_left_r  <= filt_new;
        stand_left_r <= standing;
      end
      if (is_right) begin
        filt_right_r  <= filt_new;
        stand_right_r <= standing;
      end
      if (is_tick) begin
        last_phase_r <= phase_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_kind_r  <= out_kind_nxt;
      out_phase_r <= out_phase_nxt;
      out_press_r <= out_press_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind              = out_kind_r;
  assign out_ch.phase             = out_phase_r;
  assign out_ch.filtered_pressure = out_press_r;

  a_phase_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_PHASE)) |-> (out_phase_r == last_phase_r))
    else $error("phase result differs from last phase");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_op_r) && $stable(s1_sum_r)))
    else $error("stalled input stage lost its item");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (s1_emit && out_valid_r && !out_ch.ready))
    else $error("input stage stalled without a blocked result");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the foot support phase detector. Samples and ticks
// go through the input channel with random gaps. The result channel stalls
// at random. A predictor keeps its own filter state and register copies and
// checks every result transfer in order, field by field. Runs cover several
// register settings, including the extremes, a long receiver hold-off and a
// sender pause for drain.
// ----------------------------------------------------------------------------
module testbench;
  import fspd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct {
    op_t               op;
    logic [CELL_W-1:0] lb;
    logic [CELL_W-1:0] lf;
    logic [CELL_W-1:0] rf;
    logic [CELL_W-1:0] rb;
    int unsigned       pause_after;
    bit                wait_drain;
  } sample_t;

  typedef struct {
    kind_t              kind;
    phase_t             phase;
    logic [PRESS_W-1:0] pressure;
  } detector_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = REG_FILTER_WEIGHT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fspd_in_if  in_ch ();
  fspd_out_if out_ch ();

  foot_support_phase_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sample_t       sample_q[$];
  detector_out_t detector_out_q[$];

  logic [WEIGHT_W-1:0] weight_m;
  logic [THRESH_W-1:0] thr_left_m;
  logic [THRESH_W-1:0] thr_right_m;
  logic                debug_m;
  logic [PRESS_W-1:0]  filt_left;
  logic [PRESS_W-1:0]  filt_right;
  logic                stand_left;
  logic                stand_right;
  phase_t              last_phase;

  int unsigned in_xfers = 0;
  int unsigned out_xfers = 0;
  int unsigned offered = 0;
  int unsigned idle_left = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned long_hold_at = 32'hFFFF_FFFF;
  bit          long_hold_done = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned errors = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic step_detector(input sample_t s);
    logic [PRESS_W-1:0] sum;
    logic [PRESS_W-1:0] old;
    logic [PRESS_W-1:0] nv;
    logic [35:0]        acc;
    phase_t             ph;
    detector_out_t      r;
    if (s.op == OP_LEFT || s.op == OP_RIGHT) begin
      sum = PRESS_W'(s.lb) + PRESS_W'(s.lf) + PRESS_W'(s.rf) + PRESS_W'(s.rb);
      old = (s.op == OP_LEFT) ? filt_left : filt_right;
      acc = (36'd65536 - 36'(weight_m)) * 36'(sum) + 36'(weight_m) * 36'(old);
      nv = acc[33:16];
      if (s.op == OP_LEFT) begin
        filt_left = nv;
        stand_left = nv > thr_left_m;
      end else begin
        filt_right = nv;
        stand_right = nv > thr_right_m;
      end
      if (debug_m) begin
        r.kind = (s.op == OP_LEFT) ? KIND_LEFT : KIND_RIGHT;
        r.phase = '0;
        r.pressure = nv;
        detector_out_q.push_back(r);
      end
    end else if (s.op == OP_TICK) begin
      if (stand_left && !stand_right) ph = PHASE_LEFT;
      else if (!stand_left && stand_right) ph = PHASE_RIGHT;
      else ph = PHASE_DOUBLE;
      if (ph != last_phase) begin
        last_phase = ph;
        r.kind = KIND_PHASE;
        r.phase = ph;
        r.pressure = '0;
        detector_out_q.push_back(r);
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    sample_t cur;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && in_xfers != offered) begin
    end else if (idle_left > 0) begin
      in_ch.valid <= 1'b0;
      idle_left--;
    end else if (sample_q.size() != 0 &&
                 !(sample_q[0].wait_drain && detector_out_q.size() != 0)) begin
      cur = sample_q.pop_front();
      in_ch.valid            <= 1'b1;
      in_ch.op               <= cur.op;
      in_ch.cell_left_back   <= cur.lb;
      in_ch.cell_left_front  <= cur.lf;
      in_ch.cell_right_front <= cur.rf;
      in_ch.cell_right_back  <= cur.rb;
      offered++;
      idle_left = cur.pause_after;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    int unsigned r;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && in_xfers >= long_hold_at) begin
      out_ch.ready <= 1'b0;
      hold_left = 299;
      long_hold_done = 1'b1;
    end else if (rx_calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        hold_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    detector_out_t want;
    sample_t       s;
    bit            moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        out_xfers++;
        moved = 1'b1;
        if (detector_out_q.size() == 0) begin
          report_mismatch("unexpected result kind", out_ch.kind, 0);
        end else begin
          want = detector_out_q.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.phase !== want.phase)
            report_mismatch("phase", out_ch.phase, want.phase);
          if (out_ch.filtered_pressure !== want.pressure)
            report_mismatch("filtered_pressure", out_ch.filtered_pressure, want.pressure);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.op = in_ch.op;
        s.lb = in_ch.cell_left_back;
        s.lf = in_ch.cell_left_front;
        s.rf = in_ch.cell_right_front;
        s.rb = in_ch.cell_right_back;
        s.pause_after = 0;
        s.wait_drain = 1'b0;
        step_detector(s);
        in_xfers++;
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FILTER_WEIGHT:   weight_m = data[WEIGHT_W-1:0];
      REG_THRESHOLD_LEFT:  thr_left_m = data[THRESH_W-1:0];
      REG_THRESHOLD_RIGHT: thr_right_m = data[THRESH_W-1:0];
      REG_DEBUG_ENABLE:    debug_m = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (sample_q.size() != 0 || in_xfers != offered || detector_out_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] tl,
                       input logic [CFG_DATA_W-1:0] tr, input logic [CFG_DATA_W-1:0] dbg);
    write_reg(REG_FILTER_WEIGHT, w);
    write_reg(REG_THRESHOLD_LEFT, tl);
    write_reg(REG_THRESHOLD_RIGHT, tr);
    write_reg(REG_DEBUG_ENABLE, dbg);
  endtask

  task automatic push_sample(input op_t op, input logic [CELL_W-1:0] lb,
                             input logic [CELL_W-1:0] lf, input logic [CELL_W-1:0] rf,
                             input logic [CELL_W-1:0] rb);
    sample_t s;
    s.op = op;
    s.lb = lb;
    s.lf = lf;
    s.rf = rf;
    s.rb = rb;
    s.pause_after = $urandom_range(0, 2);
    s.wait_drain = 1'b0;
    sample_q.push_back(s);
  endtask

  function automatic logic [CELL_W-1:0] pick_cell(input int unsigned mode);
    case (mode)
      0: return CELL_W'($urandom_range(0, 2000));
      1: return CELL_W'($urandom_range(60000, 65535));
      default: return CELL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sample_t make_sample(input bit calm);
    sample_t     s;
    int unsigned r;
    int unsigned mode;
    r = $urandom_range(0, 31);
    if (r == 0) s.op = OP_UNUSED;
    else if (r < 13) s.op = OP_LEFT;
    else if (r < 24) s.op = OP_RIGHT;
    else s.op = OP_TICK;
    r = $urandom_range(0, 9);
    mode = (r < 3) ? 0 : (r < 6) ? 1 : 2;
    s.lb = pick_cell(mode);
    s.lf = pick_cell(mode);
    s.rf = pick_cell(mode);
    s.rb = pick_cell(mode);
    r = $urandom_range(0, 99);
    if (calm) s.pause_after = 0;
    else if (r < 65) s.pause_after = 0;
    else if (r < 95) s.pause_after = $urandom_range(1, 3);
    else s.pause_after = $urandom_range(15, 50);
    s.wait_drain = ($urandom_range(0, 79) == 0);
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return 18'd0;
      1: return 18'd65535;
      2: return 18'd32768;
      3: return CFG_DATA_W'($urandom_range(0, 255));
      default: return CFG_DATA_W'($urandom_range(0, 262143));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 18'd0;
      1: return 18'd262143;
      default: return CFG_DATA_W'($urandom_range(0, 262143));
    endcase
  endfunction

  initial begin
    sample_t s;
    int      n;
    in_ch.valid            = 1'b0;
    in_ch.op               = OP_LEFT;
    in_ch.cell_left_back   = '0;
    in_ch.cell_left_front  = '0;
    in_ch.cell_right_front = '0;
    in_ch.cell_right_back  = '0;
    out_ch.ready           = 1'b0;
    weight_m    = '0;
    thr_left_m  = '0;
    thr_right_m = '0;
    debug_m     = 1'b0;
    filt_left   = '0;
    filt_right  = '0;
    stand_left  = 1'b0;
    stand_right = 1'b0;
    last_phase  = PHASE_DOUBLE;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    setup(18'h30000, 18'd1000, 18'd1000, 18'h3FFFF);
    push_sample(OP_LEFT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(OP_TICK, 16'h1234, 16'hFFFF, 16'h0000, 16'h8001);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_LEFT, '0, '0, '0, '0);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(OP_RIGHT, 16'd250, 16'd250, 16'd250, 16'd250);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_RIGHT, 16'd250, 16'd250, 16'd250, 16'd251);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_LEFT, 16'd250, 16'd250, 16'd250, 16'd250);
    push_sample(OP_LEFT, 16'd250, 16'd251, 16'd250, 16'd250);
    push_sample(OP_TICK, '0, '0, '0, '0);
    push_sample(OP_LEFT, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    push_sample(OP_RIGHT, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_sample(OP_TICK, '0, '0, '0, '0);
    drain();

    setup(18'h3FFFF, 18'd262143, 18'd0, 18'h00001);
    for (n = 0; n < 100; n++) sample_q.push_back(make_sample(1'b0));
    drain();

    setup(18'd65535, 18'd0, 18'd262143, 18'h3FFFE);
    for (n = 0; n < 100; n++) sample_q.push_back(make_sample(1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      setup(pick_weight(), pick_threshold(), pick_threshold(),
            (p == 2 || p == 5) ? 18'd1 : 18'($urandom_range(0, 1)));
      rx_calm = (p == 3);
      if (p == 5) long_hold_at = in_xfers + 30;
      for (n = 0; n < 130; n++) begin
        s = make_sample(p == 3 || p == 5);
        if (p == 2 && n == 60) s.wait_drain = 1'b1;
        sample_q.push_back(s);
      end
      drain();
    end
    rx_calm = 1'b0;

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fspd_pkg.sv
rtl/core/fspd_if.sv
rtl/core/fspd_cell_sum.sv
rtl/core/fspd_lowpass.sv
rtl/core/foot_support_phase_detector_top.sv
test/testbench.sv
